// ----- src/binary_min_heap_priority_queue_assert.svh -----
// Assertion macros for the binary min-heap priority queue checker.
// No dependencies; included by the checker file.
`ifndef BINARY_MIN_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define BINARY_MIN_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// clocked assertion, disabled while reset is low
`define BHPQ_ASSERT(label, ck, rn, prop, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error(msg);

// clocked assertion that also holds through reset
`define BHPQ_ASSERT_NR(label, ck, prop, msg) \
  label: assert property (@(posedge ck) prop) \
    else $error(msg);

`endif

// ----- src/bhpq_pkg.sv -----
// Shared types and constants of the binary min-heap priority queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bhpq_pkg;

  localparam int KEY_W    = 16;
  localparam int PAY_W    = 8;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 7;
  localparam int ENTRY_W  = KEY_W + PAY_W;

  // item kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef logic [OCC_W-1:0] occ_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic                out_valid;
    logic [KEY_W-1:0]    out_key;
    logic [PAY_W-1:0]    out_payload;
    logic [STATUS_W-1:0] status;
    occ_t                occupancy;
  } res_t;

endpackage

`default_nettype wire

// ----- src/bhpq_if.sv -----
// Valid/ready channel interfaces for the heap queue's item and result words.
// Depends on bhpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bhpq_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [bhpq_pkg::KEY_W-1:0]  key;
  logic [bhpq_pkg::PAY_W-1:0]  payload;

  modport source (output valid, output kind, output key, output payload, input ready);
  modport sink   (input valid, input kind, input key, input payload, output ready);
endinterface

interface bhpq_out_if;
  logic                          valid;
  logic                          ready;
  logic                          out_valid;
  logic [bhpq_pkg::KEY_W-1:0]    out_key;
  logic [bhpq_pkg::PAY_W-1:0]    out_payload;
  logic [bhpq_pkg::STATUS_W-1:0] status;
  logic [bhpq_pkg::OCC_W-1:0]    occupancy;

  modport source (output valid, output out_valid, output out_key, output out_payload,
                  output status, output occupancy, input ready);
  modport sink   (input valid, input out_valid, input out_key, input out_payload,
                  input status, input occupancy, output ready);
endinterface

`default_nettype wire

// ----- src/bhpq_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bhpq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/bhpq_ctrl.sv -----
// Heap sequencer: sift-up and sift-down over the heap RAM, one level per pass.
// Depends on bhpq_pkg, bhpq_if and bhpq_ram.
`timescale 1ns / 1ps
`default_nettype none

module bhpq_ctrl #(
  parameter int CAPACITY = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  bhpq_in_if.sink           in_ch,
  output logic              res_valid,
  output bhpq_pkg::res_t    res,
  input  wire logic         res_take
);

  localparam int CW = $clog2(CAPACITY + 1);   // one-based index / count
  localparam int AW = $clog2(CAPACITY);       // RAM address
  localparam logic [CW-1:0] CAP_IDX = CW'(CAPACITY);
  localparam logic [CW-1:0] ROOT    = CW'(1);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UP      = 4'd1;
  localparam logic [3:0] S_UP_CMP  = 4'd2;
  localparam logic [3:0] S_RD_ROOT = 4'd3;
  localparam logic [3:0] S_RD_LAST = 4'd4;
  localparam logic [3:0] S_DN      = 4'd5;
  localparam logic [3:0] S_DN_L    = 4'd6;
  localparam logic [3:0] S_DN_R    = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;      // hole position
  logic [CW-1:0]    cidx_r, cidx_nxt;    // left child of the hole
  bhpq_pkg::entry_t ent_r, ent_nxt;      // entry being moved
  bhpq_pkg::entry_t top_r, top_nxt;      // removed root
  bhpq_pkg::entry_t child_r, child_nxt;  // left child word
  bhpq_pkg::res_t   res_r, res_nxt;

  logic                      ram_we, ram_re;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [bhpq_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
  bhpq_pkg::entry_t          rd;

  logic [CW:0]      lchild;
  logic [CW-1:0]    idx_half;
  logic             take_right;
  bhpq_pkg::entry_t sel_ent;
  logic [CW-1:0]    sel_idx;
  bhpq_pkg::res_t   res_ins, res_rem;

  function automatic logic [AW-1:0] slot_addr(input logic [CW-1:0] idx);
    logic [CW-1:0] z;
    z = idx - 1'b1;
    return z[AW-1:0];
  endfunction

  bhpq_ram #(
    .WIDTH(bhpq_pkg::ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd        = bhpq_pkg::entry_t'(ram_rdata);
  assign lchild    = {idx_r, 1'b0};
  assign idx_half  = idx_r >> 1;
  // right child wins only when strictly smaller than the left
  assign take_right = (state_r == S_DN_R) && (child_r.key > rd.key);
  assign sel_ent   = (state_r == S_DN_R && !take_right) ? child_r : rd;
  assign sel_idx   = cidx_r + CW'(take_right);

  assign res_ins = '{out_valid: 1'b0, out_key: '0, out_payload: '0,
                     status: bhpq_pkg::ST_OK,
                     occupancy: bhpq_pkg::occ_t'(count_r)};
  assign res_rem = '{out_valid: 1'b1, out_key: top_r.key, out_payload: top_r.payload,
                     status: bhpq_pkg::ST_OK,
                     occupancy: bhpq_pkg::occ_t'(count_r)};

  assign in_ch.ready = (state_r == S_IDLE);
  assign res_valid   = (state_r == S_DONE);
  assign res         = res_r;

  // Reads and writes to the same slot never share a cycle: each pass writes the
  // hole and only then reads the next level.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    cidx_nxt  = cidx_r;
    ent_nxt   = ent_r;
    top_nxt   = top_r;
    child_nxt = child_r;
    res_nxt   = res_r;
    ram_we    = 1'b0;
    ram_waddr = slot_addr(idx_r);
    ram_wdata = ent_r;
    ram_re    = 1'b0;
    ram_raddr = '0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.kind == bhpq_pkg::KIND_INSERT) begin
            if (count_r == CAP_IDX) begin
              res_nxt = '{out_valid: 1'b0, out_key: '0, out_payload: '0,
                          status: bhpq_pkg::ST_FULL,
                          occupancy: bhpq_pkg::occ_t'(count_r)};
              state_nxt = S_DONE;
            end else begin
              count_nxt = count_r + 1'b1;
              idx_nxt   = count_r + 1'b1;
              ent_nxt   = '{key: in_ch.key, payload: in_ch.payload};
              state_nxt = S_UP;
            end
          end else begin
            if (count_r == '0) begin
              res_nxt = '{out_valid: 1'b0, out_key: '0, out_payload: '0,
                          status: bhpq_pkg::ST_EMPTY,
                          occupancy: bhpq_pkg::occ_t'(count_r)};
              state_nxt = S_DONE;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = slot_addr(ROOT);
              state_nxt = S_RD_ROOT;
            end
          end
        end
      end
      S_UP: begin
        if (idx_r == ROOT) begin
          ram_we    = 1'b1;
          res_nxt   = res_ins;
          state_nxt = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = slot_addr(idx_half);
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        ram_we = 1'b1;
        if (ent_r.key < rd.key) begin
          ram_wdata = rd;          // parent moves down into the hole
          idx_nxt   = idx_half;
          state_nxt = S_UP;
        end else begin
          res_nxt   = res_ins;
          state_nxt = S_DONE;
        end
      end
      S_RD_ROOT: begin
        top_nxt   = rd;
        ram_re    = 1'b1;
        ram_raddr = slot_addr(count_r);
        state_nxt = S_RD_LAST;
      end
      S_RD_LAST: begin
        ent_nxt   = rd;
        count_nxt = count_r - 1'b1;
        idx_nxt   = ROOT;
        state_nxt = S_DN;
      end
      S_DN: begin
        if (lchild > {1'b0, count_r}) begin
          ram_we    = 1'b1;
          res_nxt   = res_rem;
          state_nxt = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = slot_addr(lchild[CW-1:0]);
          cidx_nxt  = lchild[CW-1:0];
          state_nxt = S_DN_L;
        end
      end
      S_DN_L, S_DN_R: begin
        if (state_r == S_DN_L && cidx_r < count_r) begin
          child_nxt = rd;
          ram_re    = 1'b1;
          ram_raddr = slot_addr(cidx_r + 1'b1);
          state_nxt = S_DN_R;
        end else begin
          ram_we = 1'b1;
          if (sel_ent.key < ent_r.key) begin
            ram_wdata = sel_ent;   // smaller child moves up into the hole
            idx_nxt   = sel_idx;
            state_nxt = S_DN;
          end else begin
            res_nxt   = res_rem;
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    cidx_r  <= cidx_nxt;
    ent_r   <= ent_nxt;
    top_r   <= top_nxt;
    child_r <= child_nxt;
    res_r   <= res_nxt;
  end

endmodule

`default_nettype wire

// ----- src/binary_min_heap_priority_queue.sv -----
// Top level of the binary min-heap priority queue: sequencer plus output register.
// Depends on bhpq_pkg, bhpq_if, bhpq_ram and bhpq_ctrl.
//
// in_ch carries one item word per handshake: kind (0 insert, 1 remove), key and
// payload. out_ch returns exactly one result word per item, in order: the removed
// entry (out_valid, out_key, out_payload), a status and the occupancy after it.
// Work per item, from accept to out_ch.valid, on the single RAM read port:
//   insert: per level the parent is read, then compared and the hole written;
//           the entry is written when it reaches the root or a parent stops it;
//   remove: the root and the last entry are read, then per level the left and
//           the right child are read before the compare and the hole write (only
//           the left when it is the last child);
//   full and empty reports go straight to the result word.
// One item is worked at a time: in_ch.ready rises with the result word, so an
// item is worked through before the next one is taken.
// A stalled receiver keeps the word in the output register; the next item is
// still taken and worked, then waits with in_ch.ready low until that register frees.
// Reset (rst_n low, synchronous) empties the heap and drops any pending result;
// the heap RAM is not cleared, only slots up to the count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module binary_min_heap_priority_queue #(
  parameter int CAPACITY = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  bhpq_in_if.sink   in_ch,
  bhpq_out_if.source out_ch
);

  logic           res_valid;
  logic           res_take;
  bhpq_pkg::res_t res;

  logic           out_valid_r;
  bhpq_pkg::res_t out_word_r;

  bhpq_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .res_valid(res_valid),
    .res      (res),
    .res_take (res_take)
  );

  assign res_take = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_word_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_valid   = out_word_r.out_valid;
  assign out_ch.out_key     = out_word_r.out_key;
  assign out_ch.out_payload = out_word_r.out_payload;
  assign out_ch.status      = out_word_r.status;
  assign out_ch.occupancy   = out_word_r.occupancy;

endmodule

`default_nettype wire

// ----- src/bhpq_checker.sv -----
// Port-level checker for the heap queue, bound to the top level.
// Depends on bhpq_pkg and binary_min_heap_priority_queue_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "binary_min_heap_priority_queue_assert.svh"

module bhpq_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          out_entry_valid,
  input wire logic [bhpq_pkg::STATUS_W-1:0] out_status,
  input wire logic [bhpq_pkg::OCC_W-1:0]    out_occupancy
);

  `BHPQ_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result word dropped while stalled")

  `BHPQ_ASSERT_NR(a_reset_idle, clk, !rst_n |=> !out_valid && in_ready, "not idle after reset")

  `BHPQ_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready, "second word taken while busy")

  `BHPQ_ASSERT(a_empty_report, clk, rst_n, out_valid && out_status == bhpq_pkg::ST_EMPTY |-> !out_entry_valid && out_occupancy == '0, "empty report carries an entry")

endmodule

bind binary_min_heap_priority_queue bhpq_checker u_bhpq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_entry_valid(out_ch.out_valid),
  .out_status     (out_ch.status),
  .out_occupancy  (out_ch.occupancy)
);

`default_nettype wire
